// ===== design/mbfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Modbus frame encoder package
// Shared types, framing constants and the byte-level helper functions.
// ----------------------------------------------------------------------------
package mbfe_pkg;

  localparam logic [1:0] MODE_RTU   = 2'd0;
  localparam logic [1:0] MODE_ASCII = 2'd1;
  localparam logic [1:0] MODE_TCP   = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam int unsigned JOB_BYTES = 7;

  // One accepted input item, as held in the input register.
  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        first_byte;
    logic        last_byte;
    logic [7:0]  data_length;
    logic [15:0] transaction_tag;
  } item_t;

  // The output bytes caused by one item, in order from index 0.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      last;
  } job_t;

  // Sequencer status, used by the checks in the top level.
  typedef struct packed {
    logic busy;
    logic load;
    logic done;
    logic at_final;
  } emit_status_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v > 4'd9) begin
      r = 8'(v) - 8'd10 + 8'h41;
    end else begin
      r = 8'(v) + 8'h30;
    end
    return r;
  endfunction

  // One byte through the reflected CRC-16, eight shift steps.
  function automatic logic [15:0] crc_update(input logic [15:0] seed,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = seed ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/mbfe_if.sv =====
// ----------------------------------------------------------------------------
// Modbus frame encoder channel interfaces
// Valid/ready channels for input items, output bytes and the mode register.
// ----------------------------------------------------------------------------
interface mbfe_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic        first_byte;
  logic        last_byte;
  logic [7:0]  data_length;
  logic [15:0] transaction_tag;

  modport source (output valid, output frame_byte, output first_byte,
                  output last_byte, output data_length, output transaction_tag,
                  input ready);
  modport sink (input valid, input frame_byte, input first_byte,
                input last_byte, input data_length, input transaction_tag,
                output ready);
endinterface

interface mbfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

interface mbfe_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] protocol_mode;

  modport source (output valid, output protocol_mode, input ready);
  modport sink (input valid, input protocol_mode, output ready);
endinterface

// ===== design/mbfe_front.sv =====
// ----------------------------------------------------------------------------
// Modbus frame encoder input register
// Holds one accepted item until the byte sequencer takes it.
// ----------------------------------------------------------------------------
module mbfe_front (
  input  logic                clk,
  input  logic                rst_n,
  mbfe_in_if.sink             in_ch,
  input  logic                take,
  output logic                item_valid,
  output mbfe_pkg::item_t     item
);

  logic            valid_r;
  logic            valid_nxt;
  mbfe_pkg::item_t item_r;
  logic            accept;

  assign in_ch.ready = !valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.frame_byte      <= in_ch.frame_byte;
      item_r.first_byte      <= in_ch.first_byte;
      item_r.last_byte       <= in_ch.last_byte;
      item_r.data_length     <= in_ch.data_length;
      item_r.transaction_tag <= in_ch.transaction_tag;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== design/mbfe_build.sv =====
// ----------------------------------------------------------------------------
// Modbus frame encoder framing logic
// Runs the CRC and LRC accumulators and lays out the bytes of one item.
// ----------------------------------------------------------------------------
module mbfe_build #(
  parameter int unsigned MAX_DATA_BYTES = 252
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          mode,
  input  mbfe_pkg::item_t     item,
  input  logic                load,
  output mbfe_pkg::job_t      job
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [7:0]  lrc_r;
  logic [7:0]  lrc_nxt;
  logic [15:0] crc_seed;
  logic [7:0]  lrc_seed;
  logic [7:0]  lrc_chk;
  logic [7:0]  hex_hi;
  logic [7:0]  hex_lo;
  logic [7:0]  chk_hi;
  logic [7:0]  chk_lo;
  logic [16:0] len_in;
  logic [16:0] len_sat;
  logic [15:0] len_field;

  always_comb begin
    crc_seed  = item.first_byte ? mbfe_pkg::CRC_INIT : crc_r;
    lrc_seed  = item.first_byte ? 8'h00 : lrc_r;
    crc_nxt   = mbfe_pkg::crc_update(crc_seed, item.frame_byte);
    lrc_nxt   = lrc_seed + item.frame_byte;
    lrc_chk   = 8'h00 - lrc_nxt;
    hex_hi    = mbfe_pkg::hex_digit(item.frame_byte[7:4]);
    hex_lo    = mbfe_pkg::hex_digit(item.frame_byte[3:0]);
    chk_hi    = mbfe_pkg::hex_digit(lrc_chk[7:4]);
    chk_lo    = mbfe_pkg::hex_digit(lrc_chk[3:0]);
    len_in    = 17'(item.data_length);
    len_sat   = (len_in > 17'(MAX_DATA_BYTES)) ? 17'(MAX_DATA_BYTES) : len_in;
    len_field = 16'(len_sat + 17'd2);
  end

  always_comb begin
    job      = '0;
    job.last = item.last_byte;
    case (mode)
      mbfe_pkg::MODE_ASCII: begin
        if (item.first_byte) begin
          job.bytes[0] = mbfe_pkg::CHAR_COLON;
          job.bytes[1] = hex_hi;
          job.bytes[2] = hex_lo;
          job.bytes[3] = chk_hi;
          job.bytes[4] = chk_lo;
          job.bytes[5] = mbfe_pkg::CHAR_CR;
          job.bytes[6] = mbfe_pkg::CHAR_LF;
          job.cnt      = item.last_byte ? 3'd7 : 3'd3;
        end else begin
          job.bytes[0] = hex_hi;
          job.bytes[1] = hex_lo;
          job.bytes[2] = chk_hi;
          job.bytes[3] = chk_lo;
          job.bytes[4] = mbfe_pkg::CHAR_CR;
          job.bytes[5] = mbfe_pkg::CHAR_LF;
          job.cnt      = item.last_byte ? 3'd6 : 3'd2;
        end
      end
      mbfe_pkg::MODE_TCP: begin
        if (item.first_byte) begin
          job.bytes[0] = item.transaction_tag[15:8];
          job.bytes[1] = item.transaction_tag[7:0];
          job.bytes[2] = 8'h00;
          job.bytes[3] = 8'h00;
          job.bytes[4] = len_field[15:8];
          job.bytes[5] = len_field[7:0];
          job.bytes[6] = item.frame_byte;
          job.cnt      = 3'd7;
        end else begin
          job.bytes[0] = item.frame_byte;
          job.cnt      = 3'd1;
        end
      end
      default: begin
        // RTU, and the unused fourth code behaves the same way.
        job.bytes[0] = item.frame_byte;
        job.bytes[1] = crc_nxt[7:0];
        job.bytes[2] = crc_nxt[15:8];
        job.cnt      = item.last_byte ? 3'd3 : 3'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= mbfe_pkg::CRC_INIT;
      lrc_r <= 8'h00;
    end else if (load) begin
      crc_r <= crc_nxt;
      lrc_r <= lrc_nxt;
    end
  end

endmodule

// ===== design/mbfe_emit.sv =====
// ----------------------------------------------------------------------------
// Modbus frame encoder byte sequencer
// Holds the bytes of one item and sends them out one per accepted transfer.
// ----------------------------------------------------------------------------
module mbfe_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  input  mbfe_pkg::job_t        job,
  output logic                  load,
  mbfe_out_if.source            out_ch,
  output mbfe_pkg::emit_status_t status
);

  mbfe_pkg::job_t job_r;
  logic           busy_r;
  logic           busy_nxt;
  logic [2:0]     idx_r;
  logic [2:0]     idx_nxt;
  logic           at_final;
  logic           moved;
  logic           done;

  assign at_final = (idx_r == (job_r.cnt - 3'd1));
  assign moved    = busy_r && out_ch.ready;
  assign done     = moved && at_final;
  assign load     = job_valid && (!busy_r || done);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (moved) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job;
    end
  end

  assign out_ch.valid    = busy_r;
  assign out_ch.out_byte = job_r.bytes[idx_r];
  assign out_ch.out_last = job_r.last && at_final;

  assign status.busy     = busy_r;
  assign status.load     = load;
  assign status.done     = done;
  assign status.at_final = at_final;

endmodule

// ===== design/modbus_frame_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// Modbus frame encoder
// Wraps a stream of Modbus frame bytes as an RTU, ASCII or TCP frame.
// ----------------------------------------------------------------------------
// Usage:
// The in_ch channel takes one item per frame byte: the station address with
// first_byte set, then the function code and data, the final byte carrying
// last_byte. data_length and transaction_tag are read on the first byte only
// and then only in TCP mode. out_ch delivers the framed stream one byte per
// transfer, with out_last set on the final byte of each frame.
// cfg_ch writes the protocol mode (0 RTU, 1 ASCII, 2 TCP, 3 as RTU); it is
// always ready and should only be written while the block is idle.
// An item passes an input register and then the framing logic into the byte
// sequencer, whose register holds the output bytes that it offers on out_ch.
// The sequencer sends one byte per cycle while the receiver is ready; an item
// yields one byte for RTU and TCP data bytes, two for ASCII bytes, up to
// seven where a header or trailer is added.
// The next item is taken into the input register while the current one is
// still being sent; when the receiver stalls, the output byte holds and the
// input channel backs up once the input register is full.
// Reset clears the mode to RTU, empties both stages and restarts the CRC and
// LRC accumulators.
// ----------------------------------------------------------------------------
module modbus_frame_encoder_unit #(
  parameter int unsigned MAX_DATA_BYTES = 252
) (
  input  logic        clk,
  input  logic        rst_n,
  mbfe_in_if.sink     in_ch,
  mbfe_out_if.source  out_ch,
  mbfe_cfg_if.sink    cfg_ch
);

  logic [1:0]             mode_r;
  logic                   item_valid;
  mbfe_pkg::item_t        item;
  mbfe_pkg::job_t         job;
  logic                   load;
  mbfe_pkg::emit_status_t emit_status;

  // The mode register is the only configuration; writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mbfe_pkg::MODE_RTU;
    end else if (cfg_ch.valid) begin
      mode_r <= cfg_ch.protocol_mode;
    end
  end

  // Input register: frees itself whenever the sequencer takes its item.
  mbfe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (load),
    .item_valid (item_valid),
    .item       (item)
  );

  // Framing logic: the accumulators advance exactly when an item is loaded
  // into the sequencer, which keeps them in item order.
  mbfe_build #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_build (
    .clk   (clk),
    .rst_n (rst_n),
    .mode  (mode_r),
    .item  (item),
    .load  (load),
    .job   (job)
  );

  // Byte sequencer: reloads in the cycle its last byte is taken, so there is
  // no gap between items when the next item is already waiting.
  mbfe_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (item_valid),
    .job       (job),
    .load      (load),
    .out_ch    (out_ch),
    .status    (emit_status)
  );

  // A new item may only land in a full input register if the held item moves on.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && item_valid) |-> load)
    else $error("input register overwritten before its item was taken");

  // Finishing an item with nothing waiting leaves the output empty next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit_status.done && !item_valid) |=> !out_ch.valid)
    else $error("sequencer stayed busy after its final byte");

  // The frame end flag may only appear on the final byte of an item.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_last) |-> emit_status.at_final)
    else $error("end of frame flagged before the final byte of an item");

  // A load never happens while a non-final byte is still pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit_status.load && emit_status.busy) |-> emit_status.done)
    else $error("sequencer reloaded while bytes were still pending");

endmodule
